// ----- rtl/core/arccos_arcsin_unit_assert.svh -----
// Assertion macros shared by the arccos/arcsin unit modules that include this header.
`ifndef ARCCOS_ARCSIN_UNIT_ASSERT_SVH
`define ARCCOS_ARCSIN_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante, outside reset.
`define ACAS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define ACAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/acas_pkg.sv -----
// Shared widths, constants, types and arithmetic helpers of the arccos/arcsin unit.
package acas_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IQ        = 30;
  localparam int IN_W      = FRAC_BITS + 2;
  localparam int OUT_W     = FRAC_BITS + 3;
  localparam int MAGW      = FRAC_BITS + 1;
  localparam int XW        = IQ + 1;
  localparam int PW        = IQ + 2;
  localparam int PRW       = 2 * PW;
  localparam int QW        = IQ + 3;
  localparam int RW        = IQ;
  localparam int NW        = 2 * RW;
  localparam int REMW      = RW + 3;
  localparam int SQ_STEPS  = 2;
  localparam int SQ_STAGES = RW / SQ_STEPS;
  localparam int POLY_ST   = 12;
  localparam int OUT_SH    = IQ - FRAC_BITS;

  localparam logic [63:0] ONE_Q64 = 64'd1 << IQ;

  localparam logic [IN_W-1:0] MAG_ONE  = IN_W'(1) << FRAC_BITS;
  localparam logic [XW-1:0]   ONE_Q    = XW'(1) << IQ;
  localparam logic [XW-1:0]   THRESH_Q = XW'(9) << (IQ - 4);
  localparam logic [PRW-1:0]  PROD_RND = PRW'(1) << (IQ - 1);

  // Odd minimax arcsin coefficients, Q30 rounded to nearest
  localparam logic signed [PW-1:0] C0 =
    PW'((64'd4533422055 * ONE_Q64 + 64'd50000000000) / 64'd100000000000);
  localparam logic signed [PW-1:0] C1 =
    PW'((64'd1122621676 * ONE_Q64 + 64'd50000000000) / 64'd100000000000);
  localparam logic signed [PW-1:0] C2 =
    PW'((64'd2633428147 * ONE_Q64 + 64'd50000000000) / 64'd100000000000);
  localparam logic signed [PW-1:0] C3 =
    PW'((64'd2059633616 * ONE_Q64 + 64'd50000000000) / 64'd100000000000);
  localparam logic signed [PW-1:0] C4 =
    PW'((64'd3058204360 * ONE_Q64 + 64'd50000000000) / 64'd100000000000);
  localparam logic signed [PW-1:0] C5 =
    PW'((64'd4463053856 * ONE_Q64 + 64'd50000000000) / 64'd100000000000);
  localparam logic signed [PW-1:0] C6 =
    PW'((64'd7500036403 * ONE_Q64 + 64'd50000000000) / 64'd100000000000);
  localparam logic signed [PW-1:0] C7 =
    PW'((64'd1666666630 * ONE_Q64 + 64'd5000000000) / 64'd10000000000);

  localparam logic signed [QW-1:0] HALF_PI_Q =
    QW'((64'd15707963268 * ONE_Q64 + 64'd5000000000) / 64'd10000000000);
  localparam logic signed [QW-1:0] PI2_Q = HALF_PI_Q + HALF_PI_Q;

  localparam logic [QW-1:0] OUT_RND = (QW'(1) << OUT_SH) >> 1;

  localparam logic signed [OUT_W-1:0] ANGLE_MAX =
    OUT_W'((QW'(PI2_Q) + OUT_RND) >> OUT_SH);
  localparam logic signed [OUT_W-1:0] ANGLE_HALF =
    OUT_W'((QW'(HALF_PI_Q) + OUT_RND) >> OUT_SH);
  localparam logic signed [OUT_W-1:0] ANGLE_MIN = -ANGLE_HALF;

  typedef struct packed {
    logic valid;
    logic op;
    logic neg;
    logic big;
  } acas_side_t;

  typedef struct packed {
    logic           neg;
    logic [PRW-1:0] mag;
  } acas_prod_t;

  typedef struct packed {
    logic [NW-1:0]   rad;
    logic [REMW-1:0] rem;
    logic [RW-1:0]   root;
  } acas_sq_t;

  function automatic logic [PW-1:0] acas_abs(input logic signed [PW-1:0] a);
    return a[PW-1] ? (PW'(0) - a) : a;
  endfunction

  // Sign-magnitude product, exact
  function automatic acas_prod_t acas_mul(input logic signed [PW-1:0] a,
                                          input logic signed [PW-1:0] b);
    logic [PW-1:0] ma;
    logic [PW-1:0] mb;
    acas_prod_t    p;
    ma    = acas_abs(a);
    mb    = acas_abs(b);
    p.neg = a[PW-1] ^ b[PW-1];
    p.mag = ma * mb;
    return p;
  endfunction

  // Back to Q30, magnitude rounded half away from zero
  function automatic logic signed [PW-1:0] acas_rnd(input acas_prod_t p);
    logic [PRW-1:0] s;
    logic [PW-1:0]  m;
    s = p.mag + PROD_RND;
    m = PW'(s >> IQ);
    return p.neg ? (PW'(0) - m) : m;
  endfunction

  // One digit of the restoring square root
  function automatic acas_sq_t acas_sq_step(input acas_sq_t a);
    logic [REMW-1:0] r2;
    logic [REMW-1:0] trial;
    acas_sq_t        o;
    r2    = {a.rem[REMW-3:0], a.rad[NW-1 -: 2]};
    trial = REMW'({a.root, 2'b01});
    o.rad = a.rad << 2;
    if (r2 >= trial) begin
      o.rem  = r2 - trial;
      o.root = {a.root[RW-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {a.root[RW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ----- rtl/core/acas_front.sv -----
// Input stages: magnitude, saturation, branch pick and square root radicand.
module acas_front import acas_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_op_select,
  input  logic signed [IN_W-1:0] in_x_value,
  output logic                   in_stall,
  input  logic                   hold,
  output acas_side_t             side,
  output logic [XW-1:0]          xa,
  output logic [NW-1:0]          rad
);

  `include "arccos_arcsin_unit_assert.svh"

  logic            en_a;
  logic [IN_W-1:0] raw;
  logic [IN_W-1:0] magf;
  logic [MAGW-1:0] mag_nxt;
  logic [XW-1:0]   xa_nxt;
  logic [XW-1:0]   v;
  logic [NW-1:0]   rad_nxt;

  acas_side_t      a_side_r;
  acas_side_t      a_side_nxt;
  logic [MAGW-1:0] a_mag_r;
  acas_side_t      b_side_r;
  acas_side_t      b_side_nxt;
  logic [XW-1:0]   b_xa_r;
  logic [NW-1:0]   b_rad_r;

  // An empty first stage still loads while the rest of the pipe holds
  assign en_a     = !hold || !a_side_r.valid;
  assign in_stall = !en_a;

  always_comb begin
    raw              = in_x_value;
    magf             = raw[IN_W-1] ? (IN_W'(0) - raw) : raw;
    mag_nxt          = (magf > MAG_ONE) ? MAGW'(MAG_ONE) : MAGW'(magf);
    a_side_nxt.valid = in_valid;
    a_side_nxt.op    = in_op_select;
    a_side_nxt.neg   = raw[IN_W-1];
    a_side_nxt.big   = 1'b0;
  end

  always_comb begin
    xa_nxt         = XW'(a_mag_r) << (IQ - FRAC_BITS);
    v              = (ONE_Q - xa_nxt) >> 1;
    rad_nxt        = NW'(v) << IQ;
    b_side_nxt     = a_side_r;
    b_side_nxt.big = xa_nxt > THRESH_Q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_side_r <= '0;
      b_side_r <= '0;
    end else begin
      if (en_a) begin
        a_side_r <= a_side_nxt;
      end
      if (!hold) begin
        b_side_r <= b_side_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_mag_r <= mag_nxt;
    end
    if (!hold) begin
      b_xa_r  <= xa_nxt;
      b_rad_r <= rad_nxt;
    end
  end

  assign side = b_side_r;
  assign xa   = b_xa_r;
  assign rad  = b_rad_r;

  `ACAS_ASSERT_NEXT(a_fr_load, in_valid && !in_stall, a_side_r.valid, "accepted beat lost at entry")

endmodule

// ----- rtl/core/acas_sqrt.sv -----
// Pipelined restoring square root, two result bits per stage, then argument select.
module acas_sqrt import acas_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 hold,
  input  acas_side_t           side_i,
  input  logic [XW-1:0]        xa_i,
  input  logic [NW-1:0]        rad_i,
  output acas_side_t           side_o,
  output logic signed [PW-1:0] x_o
);

  `include "arccos_arcsin_unit_assert.svh"

  acas_sq_t      sq_in   [SQ_STAGES];
  acas_sq_t      sq_nxt  [SQ_STAGES];
  acas_sq_t      sq_r    [SQ_STAGES];
  acas_side_t    side_in [SQ_STAGES];
  acas_side_t    side_r  [SQ_STAGES];
  logic [XW-1:0] xa_in   [SQ_STAGES];
  logic [XW-1:0] xa_r    [SQ_STAGES];

  acas_side_t          sel_side_r;
  logic signed [PW-1:0] sel_x_r;
  logic signed [PW-1:0] sel_x_nxt;
  logic [REMW-1:0]      rem_lim;

  always_comb begin
    sq_in[0].rad  = rad_i;
    sq_in[0].rem  = '0;
    sq_in[0].root = '0;
    side_in[0]    = side_i;
    xa_in[0]      = xa_i;
    for (int s = 1; s < SQ_STAGES; s++) begin
      sq_in[s]   = sq_r[s-1];
      side_in[s] = side_r[s-1];
      xa_in[s]   = xa_r[s-1];
    end
    for (int s = 0; s < SQ_STAGES; s++) begin
      sq_nxt[s] = sq_in[s];
      for (int k = 0; k < SQ_STEPS; k++) begin
        sq_nxt[s] = acas_sq_step(sq_nxt[s]);
      end
    end
  end

  // Large arguments use the root, small ones pass straight through
  assign sel_x_nxt = side_r[SQ_STAGES-1].big ? PW'(sq_r[SQ_STAGES-1].root)
                                             : PW'(xa_r[SQ_STAGES-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SQ_STAGES; s++) begin
        side_r[s] <= '0;
      end
      sel_side_r <= '0;
    end else if (!hold) begin
      for (int s = 0; s < SQ_STAGES; s++) begin
        side_r[s] <= side_in[s];
      end
      sel_side_r <= side_r[SQ_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      for (int s = 0; s < SQ_STAGES; s++) begin
        sq_r[s] <= sq_nxt[s];
        xa_r[s] <= xa_in[s];
      end
      sel_x_r <= sel_x_nxt;
    end
  end

  assign side_o  = sel_side_r;
  assign x_o     = sel_x_r;
  assign rem_lim = REMW'({sq_r[SQ_STAGES-1].root, 1'b0});

  `ACAS_ASSERT_SAME(a_sq_rem, side_r[SQ_STAGES-1].valid, sq_r[SQ_STAGES-1].rem <= rem_lim, "square root remainder above twice the root")

endmodule

// ----- rtl/core/acas_poly.sv -----
// Pipelined odd minimax arcsin polynomial, Estrin and Horner mix, one multiply level per stage pair.
module acas_poly import acas_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 hold,
  input  acas_side_t           side_i,
  input  logic signed [PW-1:0] x_i,
  output acas_side_t           side_o,
  output logic signed [PW-1:0] core_o
);

  `include "arccos_arcsin_unit_assert.svh"

  acas_side_t side_r [POLY_ST];

  acas_prod_t           p0_x2m_r;
  logic signed [PW-1:0] p0_x_r;
  logic signed [PW-1:0] p1_x2_r, p1_x_r;
  acas_prod_t           p2_x4m_r, p2_am_r, p2_bm_r, p2_qm_r, p2_rm_r;
  logic signed [PW-1:0] p2_x2_r, p2_x_r;
  logic signed [PW-1:0] p3_x4_r, p3_a_r, p3_b_r, p3_q_r, p3_r_r, p3_x2_r, p3_x_r;
  acas_prod_t           p4_x8m_r, p4_pam_r, p4_qxm_r;
  logic signed [PW-1:0] p4_b_r, p4_r_r, p4_x2_r, p4_x_r;
  logic signed [PW-1:0] p5_x8_r, p5_p_r, p5_qx_r, p5_r_r, p5_x2_r, p5_x_r;
  acas_prod_t           p6_psm_r;
  logic signed [PW-1:0] p6_qx_r, p6_r_r, p6_x2_r, p6_x_r;
  logic signed [PW-1:0] p7_s_r, p7_x2_r, p7_x_r;
  acas_prod_t           p8_sxm_r;
  logic signed [PW-1:0] p8_x_r;
  logic signed [PW-1:0] p9_sx2_r, p9_x_r;
  acas_prod_t           p10_cm_r;
  logic signed [PW-1:0] p10_x_r;
  logic signed [PW-1:0] p11_core_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < POLY_ST; s++) begin
        side_r[s] <= '0;
      end
    end else if (!hold) begin
      side_r[0] <= side_i;
      for (int s = 1; s < POLY_ST; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      // x^2
      p0_x2m_r <= acas_mul(x_i, x_i);
      p0_x_r   <= x_i;
      p1_x2_r  <= acas_rnd(p0_x2m_r);
      p1_x_r   <= p0_x_r;
      // x^4 and the four first-order pairs
      p2_x4m_r <= acas_mul(p1_x2_r, p1_x2_r);
      p2_am_r  <= acas_mul(C0, p1_x2_r);
      p2_bm_r  <= acas_mul(C2, p1_x2_r);
      p2_qm_r  <= acas_mul(C4, p1_x2_r);
      p2_rm_r  <= acas_mul(C6, p1_x2_r);
      p2_x2_r  <= p1_x2_r;
      p2_x_r   <= p1_x_r;
      p3_x4_r  <= acas_rnd(p2_x4m_r);
      p3_a_r   <= acas_rnd(p2_am_r) - C1;
      p3_b_r   <= acas_rnd(p2_bm_r) + C3;
      p3_q_r   <= acas_rnd(p2_qm_r) + C5;
      p3_r_r   <= acas_rnd(p2_rm_r) + C7;
      p3_x2_r  <= p2_x2_r;
      p3_x_r   <= p2_x_r;
      // x^8, p and q*x^4
      p4_x8m_r <= acas_mul(p3_x4_r, p3_x4_r);
      p4_pam_r <= acas_mul(p3_a_r, p3_x4_r);
      p4_qxm_r <= acas_mul(p3_q_r, p3_x4_r);
      p4_b_r   <= p3_b_r;
      p4_r_r   <= p3_r_r;
      p4_x2_r  <= p3_x2_r;
      p4_x_r   <= p3_x_r;
      p5_x8_r  <= acas_rnd(p4_x8m_r);
      p5_p_r   <= acas_rnd(p4_pam_r) + p4_b_r;
      p5_qx_r  <= acas_rnd(p4_qxm_r);
      p5_r_r   <= p4_r_r;
      p5_x2_r  <= p4_x2_r;
      p5_x_r   <= p4_x_r;
      // s = p*x^8 + q*x^4 + r
      p6_psm_r <= acas_mul(p5_p_r, p5_x8_r);
      p6_qx_r  <= p5_qx_r;
      p6_r_r   <= p5_r_r;
      p6_x2_r  <= p5_x2_r;
      p6_x_r   <= p5_x_r;
      p7_s_r   <= acas_rnd(p6_psm_r) + p6_qx_r + p6_r_r;
      p7_x2_r  <= p6_x2_r;
      p7_x_r   <= p6_x_r;
      // Horner tail: (s*x^2)*x + x
      p8_sxm_r <= acas_mul(p7_s_r, p7_x2_r);
      p8_x_r   <= p7_x_r;
      p9_sx2_r <= acas_rnd(p8_sxm_r);
      p9_x_r   <= p8_x_r;
      p10_cm_r <= acas_mul(p9_sx2_r, p9_x_r);
      p10_x_r  <= p9_x_r;
      p11_core_r <= acas_rnd(p10_cm_r) + p10_x_r;
    end
  end

  assign side_o = side_r[POLY_ST-1];
  assign core_o = p11_core_r;

  `ACAS_ASSERT_SAME(a_core_sign, side_r[POLY_ST-1].valid, !p11_core_r[PW-1], "negative arcsin core for a nonnegative argument")

endmodule

// ----- rtl/core/acas_fold.sv -----
// Output stages: range fold, reflection, arcsin offset, rounding and the output register.
module acas_fold import acas_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    hold,
  input  acas_side_t              side_i,
  input  logic signed [PW-1:0]    core_i,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_angle
);

  acas_side_t           f0_side_r, f1_side_r, f2_side_r;
  logic signed [QW-1:0] f0_t_r, f1_t_r;
  logic signed [QW-1:0] core_x;
  logic signed [QW-1:0] t0_nxt, tr, t1_nxt;
  logic [QW-1:0]        tmag;
  logic [QW-1:0]        m_nxt;
  logic                 f2_neg_r;
  logic [QW-1:0]        f2_m_r;
  logic                 out_valid_r;
  logic signed [OUT_W-1:0] out_angle_r;

  always_comb begin
    core_x = QW'(core_i);
    t0_nxt = side_i.big ? (core_x <<< 1) : (HALF_PI_Q - core_x);
    tr     = f0_side_r.neg ? (PI2_Q - f0_t_r) : f0_t_r;
    t1_nxt = f0_side_r.op ? (HALF_PI_Q - tr) : tr;
    tmag   = f1_t_r[QW-1] ? (QW'(0) - f1_t_r) : f1_t_r;
    m_nxt  = (tmag + OUT_RND) >> OUT_SH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_side_r   <= '0;
      f1_side_r   <= '0;
      f2_side_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (!hold) begin
      f0_side_r   <= side_i;
      f1_side_r   <= f0_side_r;
      f2_side_r   <= f1_side_r;
      out_valid_r <= f2_side_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      f0_t_r      <= t0_nxt;
      f1_t_r      <= t1_nxt;
      f2_neg_r    <= f1_t_r[QW-1];
      f2_m_r      <= m_nxt;
      out_angle_r <= OUT_W'(f2_neg_r ? (QW'(0) - f2_m_r) : f2_m_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;

endmodule

// ----- rtl/core/arccos_arcsin_unit.sv -----
// Top level of the pipelined arccos/arcsin unit.
//
//   channel  direction  beat                         control
//   in_      input      op_select, x_value (Q2.16)   in_valid / in_stall
//   out_     output     angle (Q3.16 radians)        out_valid / out_stall
//
// One beat enters per cycle while in_stall is low; each result passes through
// the 15-stage square root and the 12-stage multiply chain.
// Synchronous active-low reset clears only the side-band and valid registers, not the data.
// A stalled output freezes the whole pipe; an empty entry stage still
// takes one more beat, so in_stall rises only when that stage is full.
module arccos_arcsin_unit import acas_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_op_select,
  input  logic signed [IN_W-1:0]  in_x_value,
  output logic                    in_stall,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_angle,
  input  logic                    out_stall
);

  `include "arccos_arcsin_unit_assert.svh"

  logic                 hold;
  acas_side_t           fr_side, sq_side, pl_side;
  logic [XW-1:0]        fr_xa;
  logic [NW-1:0]        fr_rad;
  logic signed [PW-1:0] sq_x;
  logic signed [PW-1:0] pl_core;

  // Freeze the pipe, all but an empty entry stage, while a finished beat waits
  assign hold = out_valid && out_stall;

  acas_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_op_select (in_op_select),
    .in_x_value   (in_x_value),
    .in_stall     (in_stall),
    .hold         (hold),
    .side         (fr_side),
    .xa           (fr_xa),
    .rad          (fr_rad)
  );

  acas_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .hold   (hold),
    .side_i (fr_side),
    .xa_i   (fr_xa),
    .rad_i  (fr_rad),
    .side_o (sq_side),
    .x_o    (sq_x)
  );

  acas_poly u_poly (
    .clk    (clk),
    .rst_n  (rst_n),
    .hold   (hold),
    .side_i (sq_side),
    .x_i    (sq_x),
    .side_o (pl_side),
    .core_o (pl_core)
  );

  acas_fold u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (hold),
    .side_i    (pl_side),
    .core_i    (pl_core),
    .out_valid (out_valid),
    .out_angle (out_angle)
  );

  `ACAS_ASSERT_SAME(a_stall_src, in_stall, out_valid && out_stall, "input stalled without a blocked output")
  `ACAS_ASSERT_SAME(a_angle_range, out_valid, out_angle >= ANGLE_MIN && out_angle <= ANGLE_MAX, "angle outside -pi/2 .. pi")

endmodule

// ----- tb/tb.sv -----
// Testbench for the arccos/arcsin unit: directed table then random arguments against a predictor.
module tb;
  import acas_pkg::FRAC_BITS;
  import acas_pkg::IN_W;
  import acas_pkg::OUT_W;

  localparam logic OP_ACOS = 1'b0;
  localparam logic OP_ASIN = 1'b1;

  localparam int                FX_FRAC   = 30;
  localparam longint unsigned   FX_ONE    = 64'd1 << FX_FRAC;
  localparam int                IN_SHIFT  = FX_FRAC - FRAC_BITS;
  localparam longint            SPLIT_PT  = longint'(64'd9 << (FX_FRAC - 4));
  localparam longint            HALF_PI_FX =
    (64'd15707963268 * FX_ONE + 64'd5000000000) / 64'd10000000000;
  localparam longint K0 = (64'd4533422055 * FX_ONE + 64'd50000000000) / 64'd100000000000;
  localparam longint K1 = (64'd1122621676 * FX_ONE + 64'd50000000000) / 64'd100000000000;
  localparam longint K2 = (64'd2633428147 * FX_ONE + 64'd50000000000) / 64'd100000000000;
  localparam longint K3 = (64'd2059633616 * FX_ONE + 64'd50000000000) / 64'd100000000000;
  localparam longint K4 = (64'd3058204360 * FX_ONE + 64'd50000000000) / 64'd100000000000;
  localparam longint K5 = (64'd4463053856 * FX_ONE + 64'd50000000000) / 64'd100000000000;
  localparam longint K6 = (64'd7500036403 * FX_ONE + 64'd50000000000) / 64'd100000000000;
  localparam longint K7 = (64'd1666666630 * FX_ONE + 64'd5000000000) / 64'd10000000000;

  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic                    op;
    logic signed [IN_W-1:0]  x;
    logic                    known;
    logic signed [OUT_W-1:0] angle;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_op_select = 1'b0;
  logic signed [IN_W-1:0]  in_x_value = '0;
  logic                    in_stall;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_angle;
  logic                    out_stall = 1'b0;

  logic signed [OUT_W-1:0] angle_queue[$];
  logic signed [OUT_W-1:0] want_angle;
  stim_row_t               dir_rows[$];
  int                      errors = 0;
  int                      gap_pct = 0;
  int                      stall_pct = 0;

  arccos_arcsin_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_op_select (in_op_select),
    .in_x_value   (in_x_value),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_angle    (out_angle),
    .out_stall    (out_stall)
  );

  initial forever #4 clk = ~clk;

  // Q30 product, magnitude rounded half away from zero
  function automatic longint fx_mul(input longint a, input longint b);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m  = (ma * mb + (64'd1 << (FX_FRAC - 1))) >> FX_FRAC;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint poly_fx(input longint x);
    longint x2, x4, x8, pa, pb, pp, pq, pr, ps;
    x2 = fx_mul(x, x);
    x4 = fx_mul(x2, x2);
    x8 = fx_mul(x4, x4);
    pa = fx_mul(K0, x2) - K1;
    pb = fx_mul(K2, x2) + K3;
    pp = fx_mul(pa, x4) + pb;
    pq = fx_mul(K4, x2) + K5;
    pr = fx_mul(K6, x2) + K7;
    ps = fx_mul(pp, x8) + fx_mul(pq, x4) + pr;
    return fx_mul(fx_mul(ps, x2), x) + x;
  endfunction

  // Floor square root of v * 2^30, Newton from above
  function automatic longint fx_sqrt(input longint unsigned v);
    longint unsigned n;
    longint unsigned y;
    longint unsigned z;
    n = v << FX_FRAC;
    y = 64'd1 << 31;
    if (n == 0) begin
      y = 0;
    end else begin
      z = (y + n / y) >> 1;
      while (z < y) begin
        y = z;
        z = (y + n / y) >> 1;
      end
    end
    return longint'(y);
  endfunction

  function automatic logic signed [OUT_W-1:0] angle_predict(input logic op,
                                                            input logic signed [IN_W-1:0] x);
    logic            neg;
    longint          sx;
    longint unsigned mag;
    longint unsigned m;
    longint          xa;
    longint          t;
    longint          r;
    neg = x[IN_W-1];
    sx  = x;
    mag = neg ? -sx : sx;
    if (mag > (64'd1 << FRAC_BITS)) mag = 64'd1 << FRAC_BITS;
    xa = longint'(mag << IN_SHIFT);
    if (xa > SPLIT_PT) begin
      t = 2 * poly_fx(fx_sqrt((FX_ONE - longint'(xa)) >> 1));
    end else begin
      t = HALF_PI_FX - poly_fx(xa);
    end
    if (neg) t = 2 * HALF_PI_FX - t;
    if (op == OP_ASIN) t = HALF_PI_FX - t;
    m = (t < 0) ? -t : t;
    m = (m + (64'd1 << (IN_SHIFT - 1))) >> IN_SHIFT;
    r = (t < 0) ? -longint'(m) : longint'(m);
    return OUT_W'(r);
  endfunction

  function automatic void add_row(input logic op, input int x, input logic known,
                                  input int angle);
    stim_row_t row;
    row.op    = op;
    row.x     = IN_W'(x);
    row.known = known;
    row.angle = OUT_W'(angle);
    dir_rows.push_back(row);
  endfunction

  // Present one beat after a random gap; hold it until taken
  task automatic send_beat(input logic op, input logic signed [IN_W-1:0] x,
                           input logic known, input logic signed [OUT_W-1:0] angle);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op_select <= op;
    in_x_value   <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    angle_queue.push_back(known ? angle : angle_predict(op, x));
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (angle_queue.size() == 0) begin
        errors++;
        $display("%0t: angle beat with none expected, got %0d", $time, out_angle);
      end else begin
        want_angle = angle_queue.pop_front();
        if (out_angle !== want_angle) begin
          errors++;
          $display("%0t: angle mismatch, expected %0d got %0d", $time, want_angle, out_angle);
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  initial begin
    int              v;
    logic            op;
    logic signed [IN_W-1:0] x;

    // exact endpoints, saturation, and both sides of the 0.5625 split
    add_row(OP_ACOS, 0, 1'b1, 102944);
    add_row(OP_ASIN, 0, 1'b1, 0);
    add_row(OP_ACOS, 65536, 1'b1, 0);
    add_row(OP_ASIN, 65536, 1'b1, 102944);
    add_row(OP_ACOS, -65536, 1'b1, 205887);
    add_row(OP_ASIN, -65536, 1'b1, -102944);
    add_row(OP_ACOS, 131071, 1'b1, 0);
    add_row(OP_ASIN, 65537, 1'b1, 102944);
    add_row(OP_ACOS, -131072, 1'b1, 205887);
    add_row(OP_ASIN, -131072, 1'b1, -102944);
    add_row(OP_ASIN, -87382, 1'b1, -102944);
    add_row(OP_ACOS, 36864, 1'b0, 0);
    add_row(OP_ACOS, 36865, 1'b0, 0);
    add_row(OP_ACOS, -36864, 1'b0, 0);
    add_row(OP_ACOS, -36865, 1'b0, 0);
    add_row(OP_ASIN, 36864, 1'b0, 0);
    add_row(OP_ASIN, -36865, 1'b0, 0);
    add_row(OP_ACOS, 1, 1'b0, 0);
    add_row(OP_ACOS, -1, 1'b0, 0);
    add_row(OP_ASIN, 65535, 1'b0, 0);
    add_row(OP_ASIN, -65535, 1'b0, 0);
    add_row(OP_ACOS, 32768, 1'b0, 0);

    gap_pct   = 34;
    stall_pct = 86;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].op, dir_rows[i].x, dir_rows[i].known, dir_rows[i].angle);
    // hold the input until the pipe is empty
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      gap_pct   = (ph == 0) ? 34 : (ph == 1) ? 86 : 0;
      stall_pct = (ph == 0) ? 86 : (ph == 1) ? 34 : 0;
      repeat (160) begin
        op = 1'($urandom_range(1));
        case ($urandom_range(9))
          0: v = int'($urandom);
          1: v = 36864 + int'($urandom_range(64)) - 32;
          2: v = 65536 - int'($urandom_range(300));
          default: v = int'($urandom_range(131072)) - 65536;
        endcase
        if (v >= 0 && v < 131072 && $urandom_range(1)) v = -v;
        x = IN_W'(v);
        send_beat(op, x, 1'b0, '0);
      end
    end

    drain_results();
    if (errors == 0 && angle_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/acas_pkg.sv
rtl/core/acas_front.sv
rtl/core/acas_sqrt.sv
rtl/core/acas_poly.sv
rtl/core/acas_fold.sv
rtl/core/arccos_arcsin_unit.sv
tb/tb.sv
